// ----- sv/pgv_pkg.sv -----
// Shared types, constants and arithmetic helpers for the projected grid vertex generator.
`timescale 1ns / 1ps
`default_nettype none

package pgv_pkg;

   localparam int MAX_GRID_SIDE    = 256;
   localparam int MATRIX_FRAC_BITS = 12;
   localparam int SIDE_W           = 9;
   localparam int SIDE_CMP_W       = 13;
   localparam int FROM_W           = 19;
   localparam int DELTA_W          = 17;
   localparam int CORNER_W         = 34;
   localparam int CORNER_SHIFT     = MATRIX_FRAC_BITS + 4;
   localparam int SUM_W            = CORNER_SHIFT + CORNER_W + 1;
   localparam int PART_W           = 44;
   localparam int BLEND_W          = 54;
   localparam int MAG_W            = 54;
   localparam int QUO_W            = 32;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MATRIX_ROW0  = 3'd0,
      REG_MATRIX_ROW1  = 3'd1,
      REG_MATRIX_ROW2  = 3'd2,
      REG_MATRIX_ROW3  = 3'd3,
      REG_PLANE_HEIGHT = 3'd4,
      REG_GRID_WIDTH   = 3'd5,
      REG_GRID_HEIGHT  = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [7:0] column;
      logic [7:0] row;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               degenerate;
   } rsp_type;

   typedef struct packed {
      logic [SIDE_W-1:0] wa;
      logic [SIDE_W-1:0] wi;
      logic [SIDE_W-1:0] wb;
      logic [SIDE_W-1:0] wj;
   } weight_type;

   typedef struct packed {
      logic       valid;
      weight_type w;
   } item_type;

   typedef logic signed [CORNER_W-1:0] corner_type;

   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic             qbit;
   } div_step_type;

   // One restoring division step: shift in one dividend bit and try to subtract.
   function automatic div_step_type div_step(input logic [MAG_W-1:0] rem,
                                             input logic din,
                                             input logic [MAG_W-1:0] dvs);
      logic [MAG_W:0] trial;
      div_step_type   res;
      trial = {rem, din};
      if (trial >= {1'b0, dvs}) begin
         res.rem  = MAG_W'(trial - {1'b0, dvs});
         res.qbit = 1'b1;
      end else begin
         res.rem  = trial[MAG_W-1:0];
         res.qbit = 1'b0;
      end
      return res;
   endfunction

   // Applies the sign to a quotient magnitude and saturates to the Q16.16 range.
   function automatic logic signed [31:0] sat_q16(input logic [QUO_W-1:0] q,
                                                  input logic ovf,
                                                  input logic neg);
      logic signed [31:0] res;
      if (neg) begin
         if (ovf || (q > 32'h8000_0000)) begin
            res = 32'sh8000_0000;
         end else begin
            res = $signed(32'd0 - q);
         end
      end else begin
         if (ovf || q[QUO_W-1]) begin
            res = 32'sh7FFF_FFFF;
         end else begin
            res = $signed(q);
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- sv/pgv_corner.sv -----
// Corner unit: projects the four screen corners and cuts each ray with the plane.
`timescale 1ns / 1ps
`default_nettype none

module pgv_corner (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   restart,
   input  wire logic [pgv_pkg::CSR_DATA_W-1:0]         matrix [4],
   input  wire logic signed [31:0]                     height,
   output logic                                        ready,
   output logic                                        ok,
   output pgv_pkg::corner_type                         corners [4][4]
);

   typedef enum logic [2:0] {
      S_LOAD,
      S_PREP,
      S_DIV,
      S_TVAL,
      S_CORN,
      S_DONE
   } state_type;

   state_type                            state_ff;
   logic [1:0]                           k_ff;
   logic [4:0]                           cnt_ff;
   logic signed [pgv_pkg::FROM_W-1:0]    from_ff [4];
   logic signed [pgv_pkg::MAG_W-1:0]     num_ff;
   logic signed [pgv_pkg::MAG_W-1:0]     den_ff;
   logic [pgv_pkg::MAG_W-1:0]            rem_ff;
   logic [pgv_pkg::MAG_W-1:0]            dvs_ff;
   logic [31:0]                          low_ff;
   logic [pgv_pkg::QUO_W-1:0]            q_ff;
   logic                                 neg_ff;
   logic                                 ovf_ff;
   logic                                 zero_ff;
   logic                                 ok_ff;
   logic                                 ready_ff;
   logic signed [31:0]                   t_ff;
   pgv_pkg::corner_type                  corners_ff [4][4];

   logic signed [15:0]                   m_el [4][4];
   logic signed [pgv_pkg::FROM_W-1:0]    from_c [4];
   logic signed [pgv_pkg::DELTA_W-1:0]   delta_c [4];
   logic signed [50:0]                   prod_nw;
   logic signed [48:0]                   prod_dw;
   logic signed [pgv_pkg::MAG_W-1:0]     num_c;
   logic signed [pgv_pkg::MAG_W-1:0]     den_c;
   logic [pgv_pkg::MAG_W-1:0]            nmag_c;
   logic [pgv_pkg::MAG_W-1:0]            dmag_c;
   pgv_pkg::div_step_type                step_c;
   logic signed [48:0]                   prod_t [4];
   logic signed [pgv_pkg::SUM_W-1:0]     sum_c [4];

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int e = 0; e < 4; e++) begin
            m_el[r][e] = $signed(matrix[r][16*e +: 16]);
         end
         from_c[r] = (k_ff[0] ? pgv_pkg::FROM_W'(m_el[r][0]) : -pgv_pkg::FROM_W'(m_el[r][0]))
                   + (k_ff[1] ? pgv_pkg::FROM_W'(m_el[r][1]) : -pgv_pkg::FROM_W'(m_el[r][1]))
                   - pgv_pkg::FROM_W'(m_el[r][2]) + pgv_pkg::FROM_W'(m_el[r][3]);
         delta_c[r] = $signed({m_el[r][2], 1'b0});
         prod_t[r]  = t_ff * delta_c[r];
         sum_c[r]   = (pgv_pkg::SUM_W'(from_ff[r]) <<< 16) + pgv_pkg::SUM_W'(prod_t[r]);
      end
      prod_nw = from_c[3] * height;
      prod_dw = delta_c[3] * height;
      num_c   = pgv_pkg::MAG_W'(prod_nw) - (pgv_pkg::MAG_W'(from_c[2]) <<< 16);
      den_c   = (pgv_pkg::MAG_W'(delta_c[2]) <<< 16) - pgv_pkg::MAG_W'(prod_dw);
      nmag_c  = num_ff[pgv_pkg::MAG_W-1] ? pgv_pkg::MAG_W'(-num_ff) : pgv_pkg::MAG_W'(num_ff);
      dmag_c  = den_ff[pgv_pkg::MAG_W-1] ? pgv_pkg::MAG_W'(-den_ff) : pgv_pkg::MAG_W'(den_ff);
      step_c  = pgv_pkg::div_step(rem_ff, low_ff[31], dvs_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         state_ff <= S_LOAD;
         k_ff     <= 2'd0;
         cnt_ff   <= 5'd0;
         ok_ff    <= 1'b1;
         ready_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_LOAD: begin
               for (int r = 0; r < 4; r++) begin
                  from_ff[r] <= from_c[r];
               end
               num_ff   <= num_c;
               den_ff   <= den_c;
               state_ff <= S_PREP;
            end
            S_PREP: begin
               neg_ff   <= num_ff[pgv_pkg::MAG_W-1] ^ den_ff[pgv_pkg::MAG_W-1];
               zero_ff  <= (den_ff == '0);
               ovf_ff   <= ({16'd0, nmag_c} >= {dmag_c, 16'd0});
               rem_ff   <= nmag_c >> 16;
               low_ff   <= {nmag_c[15:0], 16'd0};
               dvs_ff   <= dmag_c;
               cnt_ff   <= 5'd0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff <= step_c.rem;
               low_ff <= {low_ff[30:0], 1'b0};
               q_ff   <= {q_ff[pgv_pkg::QUO_W-2:0], step_c.qbit};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) begin
                  state_ff <= S_TVAL;
               end
            end
            S_TVAL: begin
               t_ff     <= zero_ff ? 32'sd0 : pgv_pkg::sat_q16(q_ff, ovf_ff, neg_ff);
               ok_ff    <= ok_ff & ~zero_ff;
               state_ff <= S_CORN;
            end
            S_CORN: begin
               for (int r = 0; r < 4; r++) begin
                  corners_ff[k_ff][r] <= sum_c[r][pgv_pkg::CORNER_SHIFT +: pgv_pkg::CORNER_W];
               end
               if (k_ff == 2'd3) begin
                  state_ff <= S_DONE;
                  ready_ff <= 1'b1;
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= S_LOAD;
               end
            end
            S_DONE: begin
               ready_ff <= 1'b1;
            end
            default: begin
               state_ff <= S_LOAD;
            end
         endcase
      end
   end

   assign ready   = ready_ff;
   assign ok      = ok_ff;
   assign corners = corners_ff;

   a_restart_clears_ready: assert property (@(posedge clock) disable iff (reset)
      restart |=> !ready_ff)
      else $error("corner unit reports ready right after a restart");

endmodule

`default_nettype wire

// ----- sv/pgv_front.sv -----
// Front end: accepts request words, clamps the indices and queues the blend weights.
`timescale 1ns / 1ps
`default_nettype none

module pgv_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire pgv_pkg::req_type                 req_data,
   input  wire logic [pgv_pkg::SIDE_W-1:0]       grid_width,
   input  wire logic [pgv_pkg::SIDE_W-1:0]       grid_height,
   input  wire logic                             corner_ready,
   output logic                                  busy,
   output pgv_pkg::item_type                     head
);

   pgv_pkg::weight_type        mem_ff [2];
   logic                       wr_ptr_ff;
   logic                       rd_ptr_ff;
   logic [1:0]                 count_ff;

   logic [pgv_pkg::SIDE_W-1:0] gw_c;
   logic [pgv_pkg::SIDE_W-1:0] gh_c;
   logic [pgv_pkg::SIDE_W-1:0] w1_c;
   logic [pgv_pkg::SIDE_W-1:0] h1_c;
   logic [pgv_pkg::SIDE_W-1:0] i_c;
   logic [pgv_pkg::SIDE_W-1:0] j_c;
   pgv_pkg::weight_type        w_c;
   logic                       push;
   logic                       pop;

   always_comb begin
      gw_c = grid_width;
      if ({4'd0, grid_width} > pgv_pkg::SIDE_CMP_W'(pgv_pkg::MAX_GRID_SIDE)) begin
         gw_c = pgv_pkg::SIDE_W'(pgv_pkg::MAX_GRID_SIDE);
      end
      if (grid_width < 9'd2) begin
         gw_c = 9'd2;
      end
      gh_c = grid_height;
      if ({4'd0, grid_height} > pgv_pkg::SIDE_CMP_W'(pgv_pkg::MAX_GRID_SIDE)) begin
         gh_c = pgv_pkg::SIDE_W'(pgv_pkg::MAX_GRID_SIDE);
      end
      if (grid_height < 9'd2) begin
         gh_c = 9'd2;
      end
      w1_c = gw_c - 9'd1;
      h1_c = gh_c - 9'd1;
      i_c  = ({1'b0, req_data.column} > w1_c) ? w1_c : {1'b0, req_data.column};
      j_c  = ({1'b0, req_data.row} > h1_c) ? h1_c : {1'b0, req_data.row};
      w_c.wa = w1_c - i_c;
      w_c.wi = i_c;
      w_c.wb = h1_c - j_c;
      w_c.wj = j_c;
   end

   assign busy = ~corner_ready | (count_ff == 2'd2);
   assign push = start & ~busy;
   assign pop  = (count_ff != 2'd0);

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= w_c;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign head.valid = pop;
   assign head.w     = mem_ff[rd_ptr_ff];

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && (count_ff == 2'd2)))
      else $error("queue written while full");

endmodule

`default_nettype wire

// ----- sv/pgv_back.sv -----
// Back end: bilinear blend of the corners and a pipelined Q16.16 divide by w.
`timescale 1ns / 1ps
`default_nettype none

module pgv_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pgv_pkg::item_type     head,
   input  wire pgv_pkg::corner_type   corners [4][4],
   input  wire logic                  corner_ok,
   output logic                       rsp_strobe,
   output pgv_pkg::rsp_type           rsp_data
);

   localparam int DIV_STAGES = pgv_pkg::QUO_W;

   logic                                  v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [pgv_pkg::PART_W-1:0]     p1_ff [4][4];
   logic [pgv_pkg::SIDE_W-1:0]            b1_ff, j1_ff, b2_ff, j2_ff;
   logic signed [pgv_pkg::PART_W-1:0]     bot2_ff [4];
   logic signed [pgv_pkg::PART_W-1:0]     top2_ff [4];
   logic signed [pgv_pkg::BLEND_W-1:0]    bot3_ff [4];
   logic signed [pgv_pkg::BLEND_W-1:0]    top3_ff [4];
   logic signed [pgv_pkg::BLEND_W-1:0]    p4_ff [4];

   logic                                  dv_valid_ff [DIV_STAGES+1];
   logic                                  dv_deg_ff [DIV_STAGES+1];
   logic [pgv_pkg::MAG_W-1:0]             dv_d_ff [DIV_STAGES+1];
   logic [pgv_pkg::MAG_W-1:0]             dv_rem_ff [DIV_STAGES+1][3];
   logic [31:0]                           dv_low_ff [DIV_STAGES+1][3];
   logic [pgv_pkg::QUO_W-1:0]             dv_q_ff [DIV_STAGES+1][3];
   logic                                  dv_neg_ff [DIV_STAGES+1][3];
   logic                                  dv_ovf_ff [DIV_STAGES+1][3];

   logic                                  out_valid_ff;
   pgv_pkg::rsp_type                      out_ff;

   logic [pgv_pkg::MAG_W-1:0]             dmag_c;
   logic [pgv_pkg::MAG_W-1:0]             nmag_c [3];
   pgv_pkg::div_step_type                 step_c [DIV_STAGES][3];

   always_comb begin
      dmag_c = p4_ff[3][pgv_pkg::BLEND_W-1] ? pgv_pkg::MAG_W'(-p4_ff[3])
                                            : pgv_pkg::MAG_W'(p4_ff[3]);
      for (int l = 0; l < 3; l++) begin
         nmag_c[l] = p4_ff[l][pgv_pkg::BLEND_W-1] ? pgv_pkg::MAG_W'(-p4_ff[l])
                                                  : pgv_pkg::MAG_W'(p4_ff[l]);
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
         for (int l = 0; l < 3; l++) begin
            step_c[s][l] = pgv_pkg::div_step(dv_rem_ff[s][l], dv_low_ff[s][l][31], dv_d_ff[s]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 4; c++) begin
         p1_ff[c][0] <= corners[0][c] * $signed({1'b0, head.w.wa});
         p1_ff[c][1] <= corners[1][c] * $signed({1'b0, head.w.wi});
         p1_ff[c][2] <= corners[2][c] * $signed({1'b0, head.w.wa});
         p1_ff[c][3] <= corners[3][c] * $signed({1'b0, head.w.wi});
         bot2_ff[c]  <= p1_ff[c][0] + p1_ff[c][1];
         top2_ff[c]  <= p1_ff[c][2] + p1_ff[c][3];
         bot3_ff[c]  <= bot2_ff[c] * $signed({1'b0, b2_ff});
         top3_ff[c]  <= top2_ff[c] * $signed({1'b0, j2_ff});
         p4_ff[c]    <= bot3_ff[c] + top3_ff[c];
      end
      b1_ff <= head.w.wb;
      j1_ff <= head.w.wj;
      b2_ff <= b1_ff;
      j2_ff <= j1_ff;

      dv_deg_ff[0] <= ~corner_ok | (p4_ff[3] == '0);
      dv_d_ff[0]   <= dmag_c;
      for (int l = 0; l < 3; l++) begin
         dv_rem_ff[0][l] <= nmag_c[l] >> 16;
         dv_low_ff[0][l] <= {nmag_c[l][15:0], 16'd0};
         dv_q_ff[0][l]   <= '0;
         dv_neg_ff[0][l] <= p4_ff[l][pgv_pkg::BLEND_W-1] ^ p4_ff[3][pgv_pkg::BLEND_W-1];
         dv_ovf_ff[0][l] <= ({16'd0, nmag_c[l]} >= {dmag_c, 16'd0});
      end

      for (int s = 0; s < DIV_STAGES; s++) begin
         dv_deg_ff[s+1] <= dv_deg_ff[s];
         dv_d_ff[s+1]   <= dv_d_ff[s];
         for (int l = 0; l < 3; l++) begin
            dv_rem_ff[s+1][l] <= step_c[s][l].rem;
            dv_low_ff[s+1][l] <= {dv_low_ff[s][l][30:0], 1'b0};
            dv_q_ff[s+1][l]   <= {dv_q_ff[s][l][pgv_pkg::QUO_W-2:0], step_c[s][l].qbit};
            dv_neg_ff[s+1][l] <= dv_neg_ff[s][l];
            dv_ovf_ff[s+1][l] <= dv_ovf_ff[s][l];
         end
      end

      out_ff.degenerate <= dv_deg_ff[DIV_STAGES];
      out_ff.pos_x <= dv_deg_ff[DIV_STAGES] ? 32'sd0 :
         pgv_pkg::sat_q16(dv_q_ff[DIV_STAGES][0], dv_ovf_ff[DIV_STAGES][0],
                          dv_neg_ff[DIV_STAGES][0]);
      out_ff.pos_y <= dv_deg_ff[DIV_STAGES] ? 32'sd0 :
         pgv_pkg::sat_q16(dv_q_ff[DIV_STAGES][1], dv_ovf_ff[DIV_STAGES][1],
                          dv_neg_ff[DIV_STAGES][1]);
      out_ff.pos_z <= dv_deg_ff[DIV_STAGES] ? 32'sd0 :
         pgv_pkg::sat_q16(dv_q_ff[DIV_STAGES][2], dv_ovf_ff[DIV_STAGES][2],
                          dv_neg_ff[DIV_STAGES][2]);

      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int s = 0; s <= DIV_STAGES; s++) begin
            dv_valid_ff[s] <= 1'b0;
         end
      end else begin
         v1_ff          <= head.valid;
         v2_ff          <= v1_ff;
         v3_ff          <= v2_ff;
         v4_ff          <= v3_ff;
         dv_valid_ff[0] <= v4_ff;
         for (int s = 0; s < DIV_STAGES; s++) begin
            dv_valid_ff[s+1] <= dv_valid_ff[s];
         end
         out_valid_ff <= dv_valid_ff[DIV_STAGES];
      end
   end

   assign rsp_strobe = out_valid_ff;
   assign rsp_data   = out_ff;

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.degenerate) |->
         (out_ff.pos_x == 32'sd0) && (out_ff.pos_y == 32'sd0) && (out_ff.pos_z == 32'sd0))
      else $error("degenerate word carries a nonzero position");

endmodule

`default_nettype wire

// ----- sv/projected_grid_vertex_gen.sv -----
// Top level of the projected grid vertex generator: registers, corner unit, front and back.
// Throughput is one vertex per cycle while busy is low, kept up by the 32-stage pipelined
// divider in the back end. After reset and after every csr write, busy stays high while
// the corner unit recomputes the four corners (four rays in turn, one serial divider).
// Reset is synchronous and restores the identity matrix, plane height 0 and a 64 by 64 grid.
// Results are never held off; rsp_strobe marks each word for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module projected_grid_vertex_gen (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire pgv_pkg::req_type                   req_data,
   output logic                                    rsp_strobe,
   output pgv_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [pgv_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [pgv_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [pgv_pkg::CSR_DATA_W-1:0] matrix_ff [4];
   logic signed [31:0]             height_ff;
   logic [pgv_pkg::SIDE_W-1:0]     gw_ff;
   logic [pgv_pkg::SIDE_W-1:0]     gh_ff;

   logic                           corner_ready;
   logic                           corner_ok;
   pgv_pkg::corner_type            corners [4][4];
   pgv_pkg::item_type              head;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff[0] <= 64'h0000_0000_0000_1000;
         matrix_ff[1] <= 64'h0000_0000_1000_0000;
         matrix_ff[2] <= 64'h0000_1000_0000_0000;
         matrix_ff[3] <= 64'h1000_0000_0000_0000;
         height_ff    <= 32'sd0;
         gw_ff        <= 9'd64;
         gh_ff        <= 9'd64;
      end else if (csr_we) begin
         case (pgv_pkg::reg_index_type'(csr_index))
            pgv_pkg::REG_MATRIX_ROW0:  matrix_ff[0] <= csr_data;
            pgv_pkg::REG_MATRIX_ROW1:  matrix_ff[1] <= csr_data;
            pgv_pkg::REG_MATRIX_ROW2:  matrix_ff[2] <= csr_data;
            pgv_pkg::REG_MATRIX_ROW3:  matrix_ff[3] <= csr_data;
            pgv_pkg::REG_PLANE_HEIGHT: height_ff    <= $signed(csr_data[31:0]);
            pgv_pkg::REG_GRID_WIDTH:   gw_ff        <= csr_data[pgv_pkg::SIDE_W-1:0];
            pgv_pkg::REG_GRID_HEIGHT:  gh_ff        <= csr_data[pgv_pkg::SIDE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   pgv_corner u_corner (
      .clock   (clock),
      .reset   (reset),
      .restart (csr_we),
      .matrix  (matrix_ff),
      .height  (height_ff),
      .ready   (corner_ready),
      .ok      (corner_ok),
      .corners (corners)
   );

   pgv_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_data     (req_data),
      .grid_width   (gw_ff),
      .grid_height  (gh_ff),
      .corner_ready (corner_ready),
      .busy         (busy),
      .head         (head)
   );

   pgv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .corners    (corners),
      .corner_ok  (corner_ok),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   a_write_sets_busy: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> busy)
      else $error("block not busy after a register write");

   a_accept_needs_corners: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> corner_ready)
      else $error("word accepted while corners are stale");

endmodule

`default_nettype wire
